// ----- design/aer_pkg.sv -----
// shared constants, types and function for the active edge relaxation block
`default_nettype none

package aer_pkg;

    // field widths
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned VTX_W      = 10;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned CNT_W      = 11;

    // register port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;

    // default store depth
    localparam int unsigned MAX_VERTICES_DEF = 1024;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELAX = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // register word indexes
    localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b0;

    // write side of the vertex and message stores
    typedef struct packed {
        logic                     msg_we;
        logic                     vtx_we;
        logic                     vtx_active;
        logic signed [DATA_W-1:0] vtx_dist;
        logic signed [DATA_W-1:0] msg_data;
    } t_store_wr;

    // read side of the stores, forwarding already applied
    typedef struct packed {
        logic                     vtx_active;
        logic signed [DATA_W-1:0] vtx_dist;
        logic signed [DATA_W-1:0] msg;
    } t_store_rd;

    // signed add clamped to the 32-bit range
    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            sat_add = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            sat_add = s[DATA_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/aer_if.sv -----
// request channels of the active edge relaxation block
`default_nettype none

interface aer_in_if import aer_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [VTX_W-1:0]         src_vertex;
    logic [VTX_W-1:0]         dst_vertex;
    logic signed [DATA_W-1:0] edge_weight;
    logic signed [DATA_W-1:0] vertex_distance;
    logic                     vertex_active;
    logic signed [DATA_W-1:0] message_init;
    logic                     last_edge;

    modport source (
        output valid, cmd, src_vertex, dst_vertex, edge_weight, vertex_distance,
               vertex_active, message_init, last_edge,
        input  ready
    );
    modport sink (
        input  valid, cmd, src_vertex, dst_vertex, edge_weight, vertex_distance,
               vertex_active, message_init, last_edge,
        output ready
    );
endinterface

interface aer_out_if import aer_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] message_value;
    logic                     edge_applied;
    logic                     pass_done;

    modport source (
        output valid, message_value, edge_applied, pass_done,
        input  ready
    );
    modport sink (
        input  valid, message_value, edge_applied, pass_done,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/aer_apb_regs.sv -----
// configuration register file behind the apb-style port
`default_nettype none

module aer_apb_regs import aer_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [CNT_W-1:0]      o_vertex_count
);

    logic [CNT_W-1:0] r_vertex_count;
    logic             wr_hit;

    // write strobe for the vertex count word
    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1:2] == REG_VERTEX_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
        end else if (wr_hit) begin
            r_vertex_count <= pwdata[CNT_W-1:0];
        end
    end

    // read-back
    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_VERTEX_COUNT) begin
            prdata = {{(APB_DATA_W-CNT_W){1'b0}}, r_vertex_count};
        end
    end

    assign o_vertex_count = r_vertex_count;

endmodule

`default_nettype wire

// ----- design/aer_store.sv -----
// vertex and message stores with clearing sweep and write forwarding
`default_nettype none

module aer_store import aer_pkg::*; #(
    parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
    localparam int unsigned AW = $clog2(MAX_VERTICES)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_vtx_addr,
    input  wire logic [AW-1:0] i_rd_msg_addr,
    input  wire logic [AW-1:0] i_s1_vtx_addr,
    input  wire logic [AW-1:0] i_s1_msg_addr,
    input  wire t_store_wr     i_wr,
    input  wire logic [AW-1:0] i_wr_addr,
    output t_store_rd          o_rd,
    output logic               o_clr_busy
);

    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_VERTICES - 1);

    // flag and distance share one word, message has its own memory
    logic [DATA_W:0]   r_vtx_mem [MAX_VERTICES];
    logic [DATA_W-1:0] r_msg_mem [MAX_VERTICES];
    logic [DATA_W:0]   r_vtx_rd;
    logic [DATA_W-1:0] r_msg_rd;

    logic              r_clr_busy;
    logic [AW-1:0]     r_clr_idx;

    logic              r_fw_vtx_valid;
    logic [AW-1:0]     r_fw_vtx_addr;
    logic [DATA_W:0]   r_fw_vtx;
    logic              r_fw_msg_valid;
    logic [AW-1:0]     r_fw_msg_addr;
    logic [DATA_W-1:0] r_fw_msg;

    logic              vtx_hit;
    logic              msg_hit;
    logic [DATA_W:0]   vtx_word;

    // clearing sweep of the frontier flags after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == LAST_IDX) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // vertex memory
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_vtx_mem[r_clr_idx] <= '0;
        end else if (i_wr.vtx_we) begin
            r_vtx_mem[i_wr_addr] <= {i_wr.vtx_active, i_wr.vtx_dist};
        end
        if (i_rd_en) begin
            r_vtx_rd <= r_vtx_mem[i_rd_vtx_addr];
        end
    end

    // message memory
    always_ff @(posedge i_clk) begin
        if (i_wr.msg_we) begin
            r_msg_mem[i_wr_addr] <= i_wr.msg_data;
        end
        if (i_rd_en) begin
            r_msg_rd <= r_msg_mem[i_rd_msg_addr];
        end
    end

    // last write to each memory, for reads issued on the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_vtx_valid <= 1'b0;
            r_fw_msg_valid <= 1'b0;
        end else begin
            if (i_wr.vtx_we) begin
                r_fw_vtx_valid <= 1'b1;
            end
            if (i_wr.msg_we) begin
                r_fw_msg_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.vtx_we) begin
            r_fw_vtx_addr <= i_wr_addr;
            r_fw_vtx      <= {i_wr.vtx_active, i_wr.vtx_dist};
        end
        if (i_wr.msg_we) begin
            r_fw_msg_addr <= i_wr_addr;
            r_fw_msg      <= i_wr.msg_data;
        end
    end

    // forwarding mux
    assign vtx_hit  = r_fw_vtx_valid && (r_fw_vtx_addr == i_s1_vtx_addr);
    assign msg_hit  = r_fw_msg_valid && (r_fw_msg_addr == i_s1_msg_addr);
    assign vtx_word = vtx_hit ? r_fw_vtx : r_vtx_rd;

    always_comb begin
        o_rd.vtx_active = vtx_word[DATA_W];
        o_rd.vtx_dist   = vtx_word[DATA_W-1:0];
        o_rd.msg        = msg_hit ? r_fw_msg : r_msg_rd;
    end

    assign o_clr_busy = r_clr_busy;

endmodule

`default_nettype wire

// ----- design/aer_relax.sv -----
// input register, relax datapath and result register
`default_nettype none

module aer_relax import aer_pkg::*; #(
    parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
    localparam int unsigned AW = $clog2(MAX_VERTICES)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    aer_in_if.sink                i_in,
    aer_out_if.source             o_out,
    input  wire logic [CNT_W-1:0] i_vertex_count,
    input  wire logic             i_clr_busy,
    input  wire t_store_rd        i_rd,
    output logic                  o_rd_en,
    output logic      [AW-1:0]    o_rd_vtx_addr,
    output logic      [AW-1:0]    o_rd_msg_addr,
    output logic      [AW-1:0]    o_s1_vtx_addr,
    output logic      [AW-1:0]    o_s1_msg_addr,
    output t_store_wr             o_wr,
    output logic      [AW-1:0]    o_wr_addr
);

    // input register
    logic                     r_s1_valid;
    logic [CMD_W-1:0]         r_s1_cmd;
    logic [VTX_W-1:0]         r_s1_src;
    logic [VTX_W-1:0]         r_s1_dst;
    logic signed [DATA_W-1:0] r_s1_weight;
    logic signed [DATA_W-1:0] r_s1_dist;
    logic                     r_s1_active;
    logic signed [DATA_W-1:0] r_s1_minit;
    logic                     r_s1_last;

    // result register
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_msg;
    logic                     r_out_applied;
    logic                     r_out_done;

    logic                     accept;
    logic                     s1_adv;
    logic                     src_in_store;
    logic                     dst_in_store;
    logic                     src_in_use;
    logic                     dst_in_use;
    logic                     applied;
    logic signed [DATA_W-1:0] cand;
    logic signed [DATA_W-1:0] n_msg;
    logic signed [DATA_W-1:0] n_out_msg;
    logic                     n_out_applied;
    logic                     n_out_done;
    t_store_wr                n_wr;
    logic [AW-1:0]            n_wr_addr;

    // handshake
    assign s1_adv      = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !i_clr_busy && (!r_s1_valid || s1_adv);
    assign accept      = i_in.valid && i_in.ready;

    // store reads issued with the request
    assign o_rd_en       = accept;
    assign o_rd_vtx_addr = AW'(i_in.src_vertex);
    assign o_rd_msg_addr = (i_in.cmd == CMD_RELAX) ? AW'(i_in.dst_vertex) : AW'(i_in.src_vertex);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd    <= i_in.cmd;
            r_s1_src    <= i_in.src_vertex;
            r_s1_dst    <= i_in.dst_vertex;
            r_s1_weight <= i_in.edge_weight;
            r_s1_dist   <= i_in.vertex_distance;
            r_s1_active <= i_in.vertex_active;
            r_s1_minit  <= i_in.message_init;
            r_s1_last   <= i_in.last_edge;
        end
    end

    assign o_s1_vtx_addr = AW'(r_s1_src);
    assign o_s1_msg_addr = (r_s1_cmd == CMD_RELAX) ? AW'(r_s1_dst) : AW'(r_s1_src);

    // bounds checks
    assign src_in_store = 32'(r_s1_src) < MAX_VERTICES;
    assign dst_in_store = 32'(r_s1_dst) < MAX_VERTICES;
    assign src_in_use   = {1'b0, r_s1_src} < i_vertex_count;
    assign dst_in_use   = {1'b0, r_s1_dst} < i_vertex_count;

    // relax: clamped candidate against the current message
    assign cand    = sat_add(i_rd.vtx_dist, r_s1_weight);
    assign applied = src_in_store && dst_in_store && src_in_use && dst_in_use
                     && i_rd.vtx_active;
    assign n_msg   = (applied && ($signed(cand) < $signed(i_rd.msg))) ? cand : i_rd.msg;

    // per-command result and store update
    always_comb begin
        n_out_msg     = '0;
        n_out_applied = 1'b0;
        n_out_done    = 1'b0;
        n_wr          = '0;
        n_wr_addr     = AW'(r_s1_src);
        case (r_s1_cmd)
            CMD_LOAD: begin
                n_wr.vtx_we     = src_in_store;
                n_wr.msg_we     = src_in_store;
                n_wr.vtx_active = r_s1_active;
                n_wr.vtx_dist   = r_s1_dist;
                n_wr.msg_data   = r_s1_minit;
                n_out_msg       = src_in_store ? r_s1_minit : '0;
            end
            CMD_RELAX: begin
                n_wr.msg_we   = applied;
                n_wr.msg_data = n_msg;
                n_wr_addr     = AW'(r_s1_dst);
                n_out_msg     = dst_in_store ? n_msg : '0;
                n_out_applied = applied;
                n_out_done    = r_s1_last;
            end
            CMD_READ: begin
                n_out_msg = src_in_store ? i_rd.msg : '0;
            end
            default: begin
                n_out_msg = '0;
            end
        endcase
    end

    // stores are written only as the request moves on
    always_comb begin
        o_wr        = n_wr;
        o_wr.vtx_we = n_wr.vtx_we && s1_adv;
        o_wr.msg_we = n_wr.msg_we && s1_adv;
    end
    assign o_wr_addr = n_wr_addr;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_msg     <= n_out_msg;
            r_out_applied <= n_out_applied;
            r_out_done    <= n_out_done;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.message_value = r_out_msg;
    assign o_out.edge_applied  = r_out_applied;
    assign o_out.pass_done     = r_out_done;

endmodule

`default_nettype wire

// ----- design/active_edge_relaxation.sv -----
// top level of the active edge relaxation block
`default_nettype none

// Scatter step of a frontier-based shortest-path pass. Requests load a
// vertex, relax an edge or read a vertex message, and each one gives exactly
// one result. One request is taken per clock while the output is not stalled
// and the clearing sweep is idle; each request passes the input register and
// then the result register: a request is registered together with the store
// reads it needs, then the relax add, compare and store write-back happen in
// one step into the result register. A write made on the same edge as a
// following read is forwarded, so back-to-back edges on one destination run at full rate.
// After reset the frontier flags are cleared by a sweep over all MAX_VERTICES
// entries during which no request is taken; the vertex count register can be
// written meanwhile. Messages must be loaded before they are read.
module active_edge_relaxation import aer_pkg::*; #(
    parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
    localparam int unsigned AW = $clog2(MAX_VERTICES)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    aer_in_if.sink                     i_in,
    aer_out_if.source                  o_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [CNT_W-1:0] vertex_count;
    logic             clr_busy;
    logic             rd_en;
    logic [AW-1:0]    rd_vtx_addr;
    logic [AW-1:0]    rd_msg_addr;
    logic [AW-1:0]    s1_vtx_addr;
    logic [AW-1:0]    s1_msg_addr;
    logic [AW-1:0]    wr_addr;
    t_store_wr        store_wr;
    t_store_rd        store_rd;

    // configuration registers
    aer_apb_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_vertex_count (vertex_count)
    );

    // vertex and message stores
    aer_store #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_en       (rd_en),
        .i_rd_vtx_addr (rd_vtx_addr),
        .i_rd_msg_addr (rd_msg_addr),
        .i_s1_vtx_addr (s1_vtx_addr),
        .i_s1_msg_addr (s1_msg_addr),
        .i_wr          (store_wr),
        .i_wr_addr     (wr_addr),
        .o_rd          (store_rd),
        .o_clr_busy    (clr_busy)
    );

    // request datapath
    aer_relax #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_relax (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .o_out          (o_out),
        .i_vertex_count (vertex_count),
        .i_clr_busy     (clr_busy),
        .i_rd           (store_rd),
        .o_rd_en        (rd_en),
        .o_rd_vtx_addr  (rd_vtx_addr),
        .o_rd_msg_addr  (rd_msg_addr),
        .o_s1_vtx_addr  (s1_vtx_addr),
        .o_s1_msg_addr  (s1_msg_addr),
        .o_wr           (store_wr),
        .o_wr_addr      (wr_addr)
    );

endmodule

`default_nettype wire
